@@ design/panned_sine_tone_generator_unit_macros.svh @@
// ----------------------------------------------------------------------------
// panned sine tone generator assertion macros
// clocked on aclk, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef PANNED_SINE_TONE_GENERATOR_UNIT_MACROS_SVH
`define PANNED_SINE_TONE_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication
`define PSTG_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSTG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/pstg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pstg_pkg
// shared types, constants and the quarter-wave sine table
// ----------------------------------------------------------------------------
package pstg_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 10;
    localparam int QUARTER         = 1 << (SINE_TABLE_BITS - 2);
    localparam int ADDR_W          = SINE_TABLE_BITS - 1;

    localparam int MUL_W      = 25;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int MAG_W      = 23;
    localparam int DIV_SHIFT  = 31;
    localparam logic [23:0] RECIP_200 = 24'd10737419;

    localparam logic [31:0] INC_RESET = 32'd46182446;
    localparam logic [14:0] VOL_RESET = 15'd6000;

    localparam int IDX_W = 8;
    localparam logic [IDX_W-1:0] REG_ENABLE = 8'd0;
    localparam logic [IDX_W-1:0] REG_INC    = 8'd1;
    localparam logic [IDX_W-1:0] REG_VOL    = 8'd2;
    localparam logic [IDX_W-1:0] REG_PAN    = 8'd3;

    localparam longint TWO_PI_Q30 = 64'sd6746518852;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_VOL,
        ST_GAIN_L,
        ST_GAIN_R,
        ST_DIV_L,
        ST_DIV_R,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_VOL,
        OP_GAIN_L,
        OP_GAIN_R,
        OP_DIV_L,
        OP_DIV_R
    } op_t;

    typedef struct packed {
        logic in_ready;
        logic mul_en;
        op_t  op;
        logic load_sine;
        logic load_sample;
        logic load_pl;
        logic load_pr;
        logic load_left;
        logic finish;
    } ctl_t;

    typedef logic [14:0] qtab_t [0:QUARTER];

    // restoring shift and subtract, non-negative operands
    function automatic longint udiv_small(input longint num, input longint den);
        longint q;
        longint r;
        int     b;
        q = 0;
        r = 0;
        for (b = 62; b >= 0; b--) begin
            r = (r << 1) | ((num >> b) & longint'(1));
            if (r >= den) begin
                r = r - den;
                q = q | (longint'(1) << b);
            end
        end
        return q;
    endfunction

    // taylor series in q30, rounded to q15 magnitude
    function automatic qtab_t build_qtab();
        qtab_t  t;
        longint x;
        longint x2;
        longint term;
        longint sum;
        longint v;
        int     m;
        int     n;
        for (m = 0; m <= QUARTER; m++) begin
            x = (longint'(m) * TWO_PI_Q30 + (longint'(1) << (SINE_TABLE_BITS - 1)))
                >>> SINE_TABLE_BITS;
            x2 = (x * x) >>> 30;
            term = x;
            sum = x;
            for (n = 1; n <= 7; n++) begin
                term = (term * x2) >>> 30;
                term = udiv_small(term, longint'((2 * n) * (2 * n + 1)));
                if (n[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = (sum * 32767 + (longint'(1) <<< 29)) >>> 30;
            if (v > 32767) begin
                v = 32767;
            end
            t[m] = 15'(v);
        end
        return t;
    endfunction

    localparam qtab_t QTAB = build_qtab();

endpackage
`default_nettype wire

@@ design/pstg_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pstg_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module pstg_mul (
    input  wire logic                                 aclk,
    input  wire logic                                 en,
    input  wire logic signed [pstg_pkg::MUL_W-1:0]    a,
    input  wire logic signed [pstg_pkg::MUL_W-1:0]    b,
    output logic signed      [pstg_pkg::PROD_W-1:0]   prod
);

    logic signed [pstg_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

@@ design/pstg_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pstg_ctrl
// sequencer stepping one frame through the shared multiplier
// ----------------------------------------------------------------------------
module pstg_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    input  wire logic           enable,
    input  wire logic           out_free,
    output pstg_pkg::ctl_t      ctl
);

    pstg_pkg::state_t state_reg;
    pstg_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pstg_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        ctl             = '0;
        ctl.op          = pstg_pkg::OP_VOL;
        case (state_reg)
            pstg_pkg::ST_IDLE: begin
                ctl.in_ready = 1'b1;
                if (in_valid && enable) begin
                    state_next = pstg_pkg::ST_READ;
                end
            end
            pstg_pkg::ST_READ: begin
                ctl.load_sine = 1'b1;
                state_next    = pstg_pkg::ST_VOL;
            end
            pstg_pkg::ST_VOL: begin
                ctl.mul_en = 1'b1;
                ctl.op     = pstg_pkg::OP_VOL;
                state_next = pstg_pkg::ST_GAIN_L;
            end
            pstg_pkg::ST_GAIN_L: begin
                ctl.load_sample = 1'b1;
                ctl.mul_en      = 1'b1;
                ctl.op          = pstg_pkg::OP_GAIN_L;
                state_next      = pstg_pkg::ST_GAIN_R;
            end
            pstg_pkg::ST_GAIN_R: begin
                ctl.load_pl = 1'b1;
                ctl.mul_en  = 1'b1;
                ctl.op      = pstg_pkg::OP_GAIN_R;
                state_next  = pstg_pkg::ST_DIV_L;
            end
            pstg_pkg::ST_DIV_L: begin
                ctl.load_pr = 1'b1;
                ctl.mul_en  = 1'b1;
                ctl.op      = pstg_pkg::OP_DIV_L;
                state_next  = pstg_pkg::ST_DIV_R;
            end
            pstg_pkg::ST_DIV_R: begin
                ctl.load_left = 1'b1;
                ctl.mul_en    = 1'b1;
                ctl.op        = pstg_pkg::OP_DIV_R;
                state_next    = pstg_pkg::ST_DONE;
            end
            pstg_pkg::ST_DONE: begin
                if (out_free) begin
                    ctl.finish = 1'b1;
                    state_next = pstg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pstg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ design/panned_sine_tone_generator_unit.sv @@
// each word is made by the table read and five passes through the single
// shared 25x25 multiplier (gain, pan split, divide by 200); no new request
// is taken until the word has been handed to the output register
// a request taken while disabled gives no word and leaves the input ready
// reset: synchronous active-low aresetn clears phase, frame count and controls
// and restores register defaults; no clearing pass
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// panned_sine_tone_generator_unit
// dds sine tone with volume and stereo pan, one word per frame request
// ----------------------------------------------------------------------------
`include "panned_sine_tone_generator_unit_macros.svh"

module panned_sine_tone_generator_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pstg_pkg::IDX_W-1:0]        cfg_index,
    input  wire logic [31:0]                       cfg_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_last_in_block,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [15:0]                     m_left_sample,
    output logic signed [15:0]                     m_right_sample,
    output logic        [31:0]                     m_frame_number,
    output logic                                   m_block_end
);

    localparam int PB = pstg_pkg::PHASE_BITS;
    localparam int TB = pstg_pkg::SINE_TABLE_BITS;
    localparam int AW = pstg_pkg::ADDR_W;
    localparam int MW = pstg_pkg::MUL_W;
    localparam int QW = pstg_pkg::MAG_W;

    pstg_pkg::ctl_t ctl;

    logic              enable_reg;
    logic [31:0]       inc_reg;
    logic [14:0]       vol_reg;
    logic signed [7:0] pan_reg;
    logic [PB-1:0]     phase_reg;
    logic [31:0]       count_reg;
    logic              blk_reg;
    logic signed [15:0] sine_reg;
    logic signed [15:0] sample_reg;
    logic              pl_neg_reg;
    logic [QW-1:0]     pl_mag_reg;
    logic              pr_neg_reg;
    logic [QW-1:0]     pr_mag_reg;
    logic signed [15:0] left_reg;
    logic              m_valid_reg;
    logic signed [15:0] m_left_reg;
    logic signed [15:0] m_right_reg;
    logic [31:0]       m_frame_reg;
    logic              m_blk_reg;

    logic              out_free;
    logic              accept;
    logic [1:0]        quad;
    logic [TB-3:0]     qpos;
    logic [AW-1:0]     taddr;
    logic [14:0]       tval;
    logic signed [15:0] sine_next;
    logic signed [7:0] pan_sat;
    logic signed [8:0] gain_l;
    logic signed [8:0] gain_r;
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [pstg_pkg::PROD_W-1:0] prod;
    logic signed [31:0] prod_lo;
    logic signed [31:0] trunc_adj;
    logic signed [15:0] sample_next;
    logic        [31:0] prod_abs;
    logic        [15:0] quot;
    logic signed [15:0] quot_signed_l;
    logic signed [15:0] quot_signed_r;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = ctl.in_ready;
    assign accept    = s_valid && ctl.in_ready;

    pstg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .enable   (enable_reg),
        .out_free (out_free),
        .ctl      (ctl)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            inc_reg    <= pstg_pkg::INC_RESET;
            vol_reg    <= pstg_pkg::VOL_RESET;
            pan_reg    <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                pstg_pkg::REG_ENABLE: enable_reg <= cfg_data[0];
                pstg_pkg::REG_INC:    inc_reg    <= cfg_data;
                pstg_pkg::REG_VOL:    vol_reg    <= cfg_data[14:0];
                pstg_pkg::REG_PAN:    pan_reg    <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // quarter-wave table lookup
    assign quad  = phase_reg[PB-1 -: 2];
    assign qpos  = phase_reg[PB-3 -: (TB-2)];
    assign taddr = quad[0] ? (AW'(pstg_pkg::QUARTER) - {1'b0, qpos}) : {1'b0, qpos};
    assign tval  = pstg_pkg::QTAB[taddr];
    assign sine_next = quad[1] ? -$signed({1'b0, tval}) : $signed({1'b0, tval});

    // pan saturation and gains
    always_comb begin
        if (pan_reg > 8'sd100) begin
            pan_sat = 8'sd100;
        end else if (pan_reg < -8'sd100) begin
            pan_sat = -8'sd100;
        end else begin
            pan_sat = pan_reg;
        end
        gain_l = 9'sd100 - 9'(pan_sat);
        gain_r = 9'sd100 + 9'(pan_sat);
    end

    // operand select
    always_comb begin
        case (ctl.op)
            pstg_pkg::OP_VOL: begin
                mul_a = MW'(sine_reg);
                mul_b = $signed({{(MW-15){1'b0}}, vol_reg});
            end
            pstg_pkg::OP_GAIN_L: begin
                mul_a = MW'(sample_next);
                mul_b = MW'(gain_l);
            end
            pstg_pkg::OP_GAIN_R: begin
                mul_a = MW'(sample_reg);
                mul_b = MW'(gain_r);
            end
            pstg_pkg::OP_DIV_L: begin
                mul_a = $signed({{(MW-QW){1'b0}}, pl_mag_reg});
                mul_b = $signed({1'b0, pstg_pkg::RECIP_200});
            end
            pstg_pkg::OP_DIV_R: begin
                mul_a = $signed({{(MW-QW){1'b0}}, pr_mag_reg});
                mul_b = $signed({1'b0, pstg_pkg::RECIP_200});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    pstg_mul u_mul (
        .aclk (aclk),
        .en   (ctl.mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // truncation toward zero of the scaled sine, magnitude of pan products
    assign prod_lo       = prod[31:0];
    assign trunc_adj     = prod_lo + (prod_lo[31] ? 32'sd32767 : 32'sd0);
    assign sample_next   = trunc_adj[30:15];
    assign prod_abs      = prod_lo[31] ? 32'(-prod_lo) : 32'(prod_lo);
    assign quot          = prod[pstg_pkg::DIV_SHIFT +: 16];
    assign quot_signed_l = pl_neg_reg ? -$signed(quot) : $signed(quot);
    assign quot_signed_r = pr_neg_reg ? -$signed(quot) : $signed(quot);

    always_ff @(posedge aclk) begin
        if (accept) begin
            blk_reg <= s_last_in_block;
        end
        if (ctl.load_sine) begin
            sine_reg <= sine_next;
        end
        if (ctl.load_sample) begin
            sample_reg <= sample_next;
        end
        if (ctl.load_pl) begin
            pl_neg_reg <= prod_lo[31];
            pl_mag_reg <= prod_abs[QW-1:0];
        end
        if (ctl.load_pr) begin
            pr_neg_reg <= prod_lo[31];
            pr_mag_reg <= prod_abs[QW-1:0];
        end
        if (ctl.load_left) begin
            left_reg <= quot_signed_l;
        end
        if (ctl.finish) begin
            m_left_reg  <= left_reg;
            m_right_reg <= quot_signed_r;
            m_frame_reg <= count_reg;
            m_blk_reg   <= blk_reg;
        end
    end

    // phase, frame count and output word valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ctl.finish) begin
                phase_reg   <= phase_reg + PB'(inc_reg);
                count_reg   <= count_reg + 32'd1;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_left_sample  = m_left_reg;
    assign m_right_sample = m_right_reg;
    assign m_frame_number = m_frame_reg;
    assign m_block_end    = m_blk_reg;

    `PSTG_ASSERT_NEXT(a_disabled_keeps_state, accept && !enable_reg,
        $stable(phase_reg) && $stable(count_reg), "disabled request changed state")
    `PSTG_ASSERT_NEXT(a_busy_after_accept, accept && enable_reg,
        !s_ready, "input ready while a word is in progress")
    `PSTG_ASSERT_IMPLY(a_no_overwrite, ctl.finish,
        !m_valid_reg || m_ready, "pending output word overwritten")
    `PSTG_ASSERT_NEXT(a_count_step, ctl.finish,
        count_reg == $past(count_reg) + 32'd1, "frame count did not advance by one")

endmodule
`default_nettype wire
